// ===== src/sbda_pkg.sv =====
// shared constants and types for the signed binary to decimal ascii converter
package sbda_pkg;

  localparam int VALUE_W    = 64;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 20;
  localparam int CHAR_W     = 6;
  localparam int COUNT_W    = 5;
  localparam int BIT_CNT_W  = 6;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_SKIP = 5'b00100,
    ST_SIGN = 5'b01000,
    ST_EMIT = 5'b10000
  } state_e;

  // per-cycle command to every digit cell
  typedef struct packed {
    logic clear;
    logic convert;
    logic dshift;
  } cell_ctrl_t;

endpackage

// ===== src/sbda_value_if.sv =====
// request channel carrying one signed 64-bit value
interface sbda_value_if;
  import sbda_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ===== src/sbda_char_if.sv =====
// request channel carrying one ascii character of the decimal text
interface sbda_char_if;
  import sbda_pkg::*;

  logic               valid;
  logic               ready;
  logic [CHAR_W-1:0]  char_code;
  logic               last_char;
  logic [COUNT_W-1:0] chars_so_far;

  modport source (output valid, output char_code, output last_char, output chars_so_far,
                  input ready);
  modport sink   (input valid, input char_code, input last_char, input chars_so_far,
                  output ready);
endinterface

// ===== src/sbda_cell.sv =====
// one bcd digit cell of the double-dabble chain
module sbda_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sbda_pkg::cell_ctrl_t                ctrl_i,
  input  logic                                bit_i,
  input  logic [sbda_pkg::DIGIT_W-1:0]        digit_i,
  output logic                                bit_o,
  output logic [sbda_pkg::DIGIT_W-1:0]        digit_o
);
  import sbda_pkg::*;

  logic [DIGIT_W-1:0] digit_q, digit_d;
  logic [DIGIT_W-1:0] adj;

  // add-3 correction before the shift
  always_comb begin
    adj = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;
  end

  // next digit: clear, shift a bit in, or take the lower neighbor's digit
  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.convert) begin
      digit_d = {adj[DIGIT_W-2:0], bit_i};
    end else if (ctrl_i.dshift) begin
      digit_d = digit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

  assign bit_o   = adj[DIGIT_W-1];
  assign digit_o = digit_q;

endmodule

// ===== src/signed_binary_to_decimal_ascii.sv =====
// signed 64-bit to decimal ascii converter: digit cell chain and sequencer
//
//  channel   dir  payload                                   handshake
//  value_i   in   value (64, signed)                        valid/ready
//  char_o    out  char_code (6), last_char (1), chars_so_far (5)  valid/ready
//
// one value is taken in the idle state; the conversion then shifts its magnitude
// through a chain of 20 bcd cells, one bit per cycle.
// leading zero digits are then dropped (up to 19), the skip state is left, and
// each character is written to the output register when that register is free.
// reset is asynchronous, active low, and returns the sequencer to idle.
// output stalls hold the character in the output register and freeze emission.
module signed_binary_to_decimal_ascii (
  input  logic         clk_i,
  input  logic         rst_ni,
  sbda_value_if.sink   value_i,
  sbda_char_if.source  char_o
);
  import sbda_pkg::*;

  localparam int TOP = NUM_DIGITS - 1;

  state_e                state_q, state_d;
  logic [VALUE_W-1:0]    mag_q, mag_d;
  logic                  neg_q, neg_d;
  logic [BIT_CNT_W-1:0]  bit_cnt_q, bit_cnt_d;
  logic [COUNT_W-1:0]    remain_q, remain_d;
  logic [COUNT_W-1:0]    chars_q, chars_d;
  cell_ctrl_t            ctrl;
  logic [VALUE_W-1:0]    raw;

  logic                  emit;
  logic [CHAR_W-1:0]     emit_code;
  logic                  emit_last;
  logic [COUNT_W-1:0]    emit_count;
  logic                  slot_free;

  logic                  out_valid_q;
  logic [CHAR_W-1:0]     out_code_q;
  logic                  out_last_q;
  logic [COUNT_W-1:0]    out_count_q;

  logic [DIGIT_W-1:0]    digit_w [NUM_DIGITS];
  logic                  carry_w [NUM_DIGITS];

  // chain of digit cells, cell 0 is the least significant digit
  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    if (i == 0) begin : g_first
      sbda_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (ctrl),
        .bit_i   (mag_q[VALUE_W-1]),
        .digit_i ({DIGIT_W{1'b0}}),
        .bit_o   (carry_w[i]),
        .digit_o (digit_w[i])
      );
    end else begin : g_next
      sbda_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (ctrl),
        .bit_i   (carry_w[i-1]),
        .digit_i (digit_w[i-1]),
        .bit_o   (carry_w[i]),
        .digit_o (digit_w[i])
      );
    end
  end

  assign raw           = value_i.value;
  assign value_i.ready = (state_q == ST_IDLE);
  assign slot_free     = !out_valid_q || char_o.ready;

  // sequencer
  always_comb begin
    state_d    = state_q;
    mag_d      = mag_q;
    neg_d      = neg_q;
    bit_cnt_d  = bit_cnt_q;
    remain_d   = remain_q;
    chars_d    = chars_q;
    ctrl       = '0;
    emit       = 1'b0;
    emit_code  = ASCII_ZERO;
    emit_last  = 1'b0;
    emit_count = chars_q + COUNT_W'(1);
    case (state_q)
      ST_IDLE: begin
        if (value_i.valid) begin
          neg_d      = raw[VALUE_W-1];
          mag_d      = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;
          bit_cnt_d  = '0;
          ctrl.clear = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        ctrl.convert = 1'b1;
        mag_d        = {mag_q[VALUE_W-2:0], 1'b0};
        bit_cnt_d    = bit_cnt_q + BIT_CNT_W'(1);
        if (bit_cnt_q == BIT_CNT_W'(VALUE_W - 1)) begin
          remain_d = COUNT_W'(NUM_DIGITS);
          state_d  = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // drop leading zeros, keeping at least one digit
        if ((digit_w[TOP] == '0) && (remain_q != COUNT_W'(1))) begin
          ctrl.dshift = 1'b1;
          remain_d    = remain_q - COUNT_W'(1);
        end else begin
          chars_d = '0;
          state_d = neg_q ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          emit       = 1'b1;
          emit_code  = ASCII_MINUS;
          emit_last  = 1'b0;
          emit_count = COUNT_W'(1);
          chars_d    = COUNT_W'(1);
          state_d    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          emit        = 1'b1;
          emit_code   = ASCII_ZERO + CHAR_W'(digit_w[TOP]);
          emit_last   = (remain_q == COUNT_W'(1));
          chars_d     = emit_count;
          ctrl.dshift = 1'b1;
          remain_d    = remain_q - COUNT_W'(1);
          if (remain_q == COUNT_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bit_cnt_q   <= '0;
      remain_q    <= '0;
      chars_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_cnt_q   <= bit_cnt_d;
      remain_q    <= remain_d;
      chars_q     <= chars_d;
      out_valid_q <= emit || (out_valid_q && !char_o.ready);
    end
  end

  // magnitude shifter and output payload
  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    neg_q <= neg_d;
    if (emit) begin
      out_code_q  <= emit_code;
      out_last_q  <= emit_last;
      out_count_q <= emit_count;
    end
  end

  assign char_o.valid        = out_valid_q;
  assign char_o.char_code    = out_code_q;
  assign char_o.last_char    = out_last_q;
  assign char_o.chars_so_far = out_count_q;

endmodule

// ===== src/sbda_checker.sv =====
// port-level checks for the converter, bound to the top level
module sbda_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic [sbda_pkg::CHAR_W-1:0]      char_code_i,
  input logic                             last_char_i,
  input logic [sbda_pkg::COUNT_W-1:0]     chars_so_far_i
);
  import sbda_pkg::*;

  logic [COUNT_W-1:0] seen_q;
  logic               busy_q;
  logic               in_acc;
  logic               out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // characters already taken for the current number, and number in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      busy_q <= 1'b0;
    end else begin
      if (out_acc) begin
        seen_q <= last_char_i ? '0 : chars_so_far_i;
      end
      if (in_acc) begin
        busy_q <= 1'b1;
      end else if (out_valid_i && last_char_i) begin
        busy_q <= 1'b0;
      end
    end
  end

  // a stalled character holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(char_code_i)
      && $stable(last_char_i) && $stable(chars_so_far_i))
    else $error("stalled character changed");

  // the count climbs by one per character within a number
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> chars_so_far_i == seen_q + COUNT_W'(1))
    else $error("character count out of sequence");

  // only the first character may be a minus sign, and never the last
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && char_code_i == ASCII_MINUS |-> chars_so_far_i == COUNT_W'(1) && !last_char_i)
    else $error("misplaced minus sign");

  // a leading zero digit is the whole number
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && char_code_i == ASCII_ZERO && chars_so_far_i == COUNT_W'(1) |-> last_char_i)
    else $error("leading zero emitted");

  // no new value taken while the previous one is still being converted
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i |-> !(busy_q && !(out_valid_i && last_char_i)))
    else $error("value accepted during conversion");

endmodule

bind signed_binary_to_decimal_ascii sbda_checker u_sbda_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (value_i.valid),
  .in_ready_i     (value_i.ready),
  .out_valid_i    (char_o.valid),
  .out_ready_i    (char_o.ready),
  .char_code_i    (char_o.char_code),
  .last_char_i    (char_o.last_char),
  .chars_so_far_i (char_o.chars_so_far)
);
